/* rtl/core/hkvt_pkg.sv */
// Shared types and constants for the hashed key-value table.
package hkvt_pkg;

    localparam logic [1:0] KIND_GET    = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_GETCRE = 2'd2;
    localparam logic [1:0] KIND_DEL    = 2'd3;

    localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int          FMIX_SHIFT = 33;

    localparam int CFG_W = 9;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key;
        logic [63:0] new_value;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [63:0] value;
        logic        created;
        logic        status;
    } t_rsp;

endpackage

/* rtl/core/hkvt_if.sv */
// Valid/ready channel interfaces for requests, responses and configuration.
interface hkvt_req_if;
    import hkvt_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] key;
    logic [63:0] new_value;
    modport source (output valid, kind, key, new_value, input ready);
    modport sink   (input valid, kind, key, new_value, output ready);
endinterface

interface hkvt_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] value;
    logic        created;
    logic        status;
    modport source (output valid, found, value, created, status, input ready);
    modport sink   (input valid, found, value, created, status, output ready);
endinterface

interface hkvt_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/hashed_key_value_table_core.sv */
// Top level of the hashed key-value table: hash unit, slot memory and scan sequencer.
//
// Channel  Dir  Payload
// req      in   kind, key, new_value
// rsp      out  found, value, created, status
// cfg      in   bucket_count
//
// Steps: the hash (fmix64, then the bucket reduction, one bit a cycle, then the bucket
// is registered), then WAYS reads, a compare and a write-back; the response word is
// registered, one request at a time.
// After reset a clearing pass zeroes the valid marks; req is held off.
// A response waiting in its output register blocks the next request until it is taken.
module hashed_key_value_table_core
    import hkvt_pkg::*;
#(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hkvt_req_if.sink     req,
    hkvt_rsp_if.source   rsp,
    hkvt_cfg_if.sink     cfg
);
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HASH = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_LAST = 3'd3;
    localparam logic [2:0] ST_ACT  = 3'd4;
    localparam logic [2:0] ST_CLR  = 3'd5;

    logic [2:0]       r_st, n_st;
    logic [CFG_W-1:0] r_cnt;
    t_req             r_req;
    logic [BW-1:0]    w_bucket;
    logic             w_hdone;
    logic [CFG_W-1:0] w_div;
    logic [AW-1:0]    r_base;
    logic [WW:0]      r_way;       // way being read
    logic [WW:0]      r_cway;      // way whose data is on the read port
    logic             r_chk;
    logic             r_hit, r_free;
    logic [AW-1:0]    r_hslot, r_fslot;
    logic [AW-1:0]    r_clr;       // clearing pass address
    logic             mem_vld [SLOTS];
    logic [63:0]      mem_key [SLOTS];
    logic [63:0]      mem_val [SLOTS];
    logic             r_rvld;
    logic [63:0]      r_rkey, r_rval, r_hval;
    logic [AW-1:0]    w_rslot;
    logic             w_we;
    logic [AW-1:0]    w_wslot;
    logic             w_vwe;
    logic [AW-1:0]    w_vaddr;
    logic             w_vdata;
    logic             r_ovld;
    t_rsp             r_rsp, w_rsp;

    assign w_div = (r_cnt == '0) ? CFG_W'(1)
                 : ((32'(r_cnt) > BUCKETS) ? CFG_W'(BUCKETS) : r_cnt);

    hkvt_hash #(.BW(BW)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (req.valid && req.ready),
        .i_key    (req.key),
        .i_div    (w_div),
        .o_done   (w_hdone),
        .o_bucket (w_bucket)
    );

    assign req.ready = (r_st == ST_IDLE) && !(r_ovld && !rsp.ready);
    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= CFG_W'(256);
        else if (cfg.valid) r_cnt <= cfg.data;
    end

    assign w_rslot = AW'(r_base + AW'(r_way));

    // memories: one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        r_rvld <= mem_vld[w_rslot];
        r_rkey <= mem_key[w_rslot];
        r_rval <= mem_val[w_rslot];
        if (w_vwe) mem_vld[w_vaddr] <= w_vdata;
        if (w_we) begin
            if (r_req.kind == KIND_SET && r_hit) begin
                mem_val[w_wslot] <= r_req.new_value;
            end else begin
                mem_key[w_wslot] <= r_req.key;
                mem_val[w_wslot] <= r_req.new_value;
            end
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_CLR:  if (r_clr == AW'(SLOTS - 1)) n_st = ST_IDLE;
            ST_IDLE: if (req.valid && req.ready) n_st = ST_HASH;
            ST_HASH: if (w_hdone) n_st = ST_SCAN;
            ST_SCAN: if (r_way == (WW+1)'(WAYS - 1)) n_st = ST_LAST;
            ST_LAST: n_st = ST_ACT;
            ST_ACT:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    assign w_wslot = r_hit ? r_hslot : r_fslot;
    assign w_we = (r_st == ST_ACT) && (r_req.kind == KIND_SET || r_req.kind == KIND_GETCRE)
                  && (r_hit ? (r_req.kind == KIND_SET) : r_free);

    // valid marks: cleared by the pass, set on insert, cleared on delete of a hit
    assign w_vwe   = (r_st == ST_CLR) ||
                     ((r_st == ST_ACT) && (w_we || (r_req.kind == KIND_DEL && r_hit)));
    assign w_vaddr = (r_st == ST_CLR) ? r_clr : w_wslot;
    assign w_vdata = (r_st == ST_ACT) && (r_req.kind != KIND_DEL);

    always_comb begin
        w_rsp.found   = r_hit;
        w_rsp.value   = '0;
        w_rsp.created = 1'b0;
        w_rsp.status  = 1'b0;
        case (r_req.kind)
            KIND_GET: if (r_hit) w_rsp.value = r_hval;
            KIND_SET: w_rsp.status = !r_hit && !r_free;
            KIND_GETCRE: begin
                if (r_hit) w_rsp.value = r_hval;
                else if (r_free) begin
                    w_rsp.value   = r_req.new_value;
                    w_rsp.created = 1'b1;
                end else w_rsp.status = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_CLR;
            r_clr   <= '0;
            r_ovld  <= 1'b0;
            r_chk   <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_chk <= (r_st == ST_SCAN);
            if (r_st == ST_CLR) r_clr <= r_clr + 1'b1;
            if (rsp.ready) r_ovld <= 1'b0;
            if (r_st == ST_ACT) r_ovld <= 1'b1;
        end
        if (req.valid && req.ready) begin
            r_req.kind      <= req.kind;
            r_req.key       <= req.key;
            r_req.new_value <= req.new_value;
        end
        if (r_st == ST_HASH) begin
            r_base <= AW'(32'(w_bucket) * WAYS);
            r_way  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end
        if (r_st == ST_SCAN) r_way <= r_way + 1'b1;
        r_cway <= r_way;
        // compare the way read last cycle
        if (r_chk) begin
            if (r_rvld) begin
                if (!r_hit && r_rkey == r_req.key) begin
                    r_hit   <= 1'b1;
                    r_hslot <= AW'(r_base + AW'(r_cway));
                    r_hval  <= r_rval;
                end
            end else if (!r_free) begin
                r_free  <= 1'b1;
                r_fslot <= AW'(r_base + AW'(r_cway));
            end
        end
        if (r_st == ST_ACT) r_rsp <= w_rsp;
    end

    assign rsp.valid   = r_ovld;
    assign rsp.found   = r_rsp.found;
    assign rsp.value   = r_rsp.value;
    assign rsp.created = r_rsp.created;
    assign rsp.status  = r_rsp.status;

`ifndef ASSERT_OFF
    a_one_hot_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid |-> !(rsp.found && rsp.created)) else $error("found and created");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> !req.ready) else $error("ready while busy");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.valid && rsp.status) |-> !rsp.found) else $error("full with hit");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_CLR) |-> !rsp.valid) else $error("response during clearing");
`endif
endmodule

/* rtl/core/hkvt_hash.sv */
// Murmur3 fmix64 over several cycles, 32x32 partial products, then bucket reduction.
module hkvt_hash
    import hkvt_pkg::*;
#(
    parameter int BW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_key,
    input  logic [CFG_W-1:0] i_div,
    output logic          o_done,
    output logic [BW-1:0] o_bucket
);
    // step: 0..3 partial products of mult 1, 4..7 of mult 2, 8 final xor, then mod
    logic [63:0] r_h, n_h;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic        r_mod, n_mod;
    logic [CFG_W-1:0] r_rem, n_rem;   // remainder bits while reducing
    logic [6:0]  r_bit, n_bit;
    logic        r_done, n_done;
    logic [63:0] w_c;
    logic [31:0] w_a, w_b;
    logic [63:0] w_pp;
    logic [127:0] w_sh;
    logic [CFG_W:0] w_trial;

    always_comb begin
        w_c = (r_step < 4'd4) ? FMIX_C1 : FMIX_C2;
        w_a = r_step[0] ? r_h[63:32] : r_h[31:0];
        w_b = r_step[1] ? w_c[63:32] : w_c[31:0];
        w_pp = {32'd0, w_a} * {32'd0, w_b};
        w_sh = {64'd0, w_pp} << (7'(r_step[0]) * 7'd32 + 7'(r_step[1]) * 7'd32);
        w_trial = {r_rem, r_h[r_bit[5:0]]};
    end

    always_comb begin
        n_h = r_h; n_acc = r_acc; n_step = r_step; n_busy = r_busy;
        n_mod = r_mod; n_rem = r_rem; n_bit = r_bit; n_done = 1'b0;
        if (i_start) begin
            n_h    = i_key ^ (i_key >> FMIX_SHIFT);
            n_acc  = '0;
            n_step = '0;
            n_busy = 1'b1;
            n_mod  = 1'b0;
        end else if (r_busy && !r_mod) begin
            if (r_step == 4'd8) begin
                n_h   = r_h ^ (r_h >> FMIX_SHIFT);
                n_mod = 1'b1;
                n_rem = '0;
                n_bit = 7'd63;
            end else begin
                if (!(r_step[0] && r_step[1]))
                    n_acc = r_acc + w_sh[63:0];
                if (r_step[1:0] == 2'd3) begin
                    n_h   = (r_acc + w_sh[63:0]) ^ ((r_acc + w_sh[63:0]) >> FMIX_SHIFT);
                    n_acc = '0;
                    if (r_step == 4'd7) n_h = r_acc + w_sh[63:0];
                end
                n_step = r_step + 4'd1;
            end
        end else if (r_busy) begin
            // restoring division, one bit a cycle
            if (w_trial >= {1'b0, i_div})
                n_rem = CFG_W'(w_trial - {1'b0, i_div});
            else
                n_rem = CFG_W'(w_trial);
            if (r_bit == 7'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
            n_bit = r_bit - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
            r_mod  <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
            r_mod  <= n_mod;
            r_bit  <= n_bit;
        end
        r_h   <= n_h;
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_done   = r_done;
    assign o_bucket = BW'(r_rem);
endmodule

/* verif/hashed_key_value_table_core_test.sv */
// Testbench for the hashed key-value table: random and directed requests against a local table model.
`timescale 1ns / 100ps

module hashed_key_value_table_core_test;
    import hkvt_pkg::*;

    localparam int BUCKETS = 256;
    localparam int WAYS    = 4;
    localparam int SLOTS   = BUCKETS * WAYS;

    // Table model: mirrors the slot store and predicts one response per request
    class table_scoreboard;
        bit          slot_used [SLOTS];
        logic [63:0] slot_key  [SLOTS];
        logic [63:0] slot_val  [SLOTS];
        logic [8:0]  bucket_count;
        t_rsp        pending_rsp [$];
        int          errors;

        function new();
            bucket_count = 9'd256;
            errors = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function logic [63:0] mix_key(logic [63:0] h);
            h = h ^ (h >> FMIX_SHIFT);
            h = h * FMIX_C1;
            h = h ^ (h >> FMIX_SHIFT);
            h = h * FMIX_C2;
            h = h ^ (h >> FMIX_SHIFT);
            return h;
        endfunction

        // Work out the response to an accepted request and update the table
        function void note_request(logic [1:0] kind, logic [63:0] key, logic [63:0] nv);
            logic [63:0] nbkt;
            int          base, hit, free_slot;
            t_rsp        r;
            nbkt = (bucket_count == 0) ? 64'd1 :
                   (bucket_count > BUCKETS) ? 64'(BUCKETS) : 64'(bucket_count);
            base = int'(mix_key(key) % nbkt) * WAYS;
            hit = -1;
            free_slot = -1;
            for (int w = 0; w < WAYS; w++) begin
                if (slot_used[base + w]) begin
                    if (hit < 0 && slot_key[base + w] == key) hit = base + w;
                end else if (free_slot < 0) begin
                    free_slot = base + w;
                end
            end
            r = '0;
            r.found = (hit >= 0);
            case (kind)
                KIND_GET: begin
                    if (hit >= 0) r.value = slot_val[hit];
                end
                KIND_SET, KIND_GETCRE: begin
                    if (hit >= 0) begin
                        if (kind == KIND_SET) slot_val[hit] = nv;
                        else r.value = slot_val[hit];
                    end else if (free_slot >= 0) begin
                        slot_used[free_slot] = 1'b1;
                        slot_key[free_slot]  = key;
                        slot_val[free_slot]  = nv;
                        if (kind == KIND_GETCRE) begin
                            r.value   = nv;
                            r.created = 1'b1;
                        end
                    end else begin
                        r.status = 1'b1;
                    end
                end
                KIND_DEL: begin
                    if (hit >= 0) slot_used[hit] = 1'b0;
                end
            endcase
            pending_rsp.push_back(r);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (pending_rsp.size() == 0) begin
                $error("response word with none expected");
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.value !== want.value) begin
                $error("value: expected %h, got %h", want.value, got.value);
                errors++;
            end
            if (got.created !== want.created) begin
                $error("created: expected %0d, got %0d", want.created, got.created);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hkvt_req_if req ();
    hkvt_rsp_if rsp ();
    hkvt_cfg_if cfg ();

    hashed_key_value_table_core #(.BUCKETS(BUCKETS), .WAYS(WAYS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .cfg     (cfg.sink)
    );

    always #10 i_clk = ~i_clk;

    table_scoreboard board = new();
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic [63:0] key_pool [$];

    initial begin
        req.valid = 1'b0;
        req.kind = KIND_GET;
        req.key = '0;
        req.new_value = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
    end

    // Receiver side: random back-pressure on the response channel
    always @(posedge i_clk) begin
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_rsp got;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            got.found   = rsp.found;
            got.value   = rsp.value;
            got.created = rsp.created;
            got.status  = rsp.status;
            board.check_response(got);
        end
    end

    // One request word; valid is only dropped when a gap is taken
    task automatic send_request(logic [1:0] kind, logic [63:0] key, logic [63:0] nv);
        if ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        req.valid     <= 1'b1;
        req.kind      <= kind;
        req.key       <= key;
        req.new_value <= nv;
        do @(posedge i_clk); while (!req.ready);
        board.note_request(kind, key, nv);
    endtask

    // Register writes only once the table has drained; the pause covers the pipeline
    task automatic write_buckets(logic [8:0] n);
        req.valid <= 1'b0;
        while (board.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.data  <= n;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        board.bucket_count = n;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_words(int count, int pool_size);
        logic [63:0] k;
        key_pool = {};
        for (int i = 0; i < pool_size; i++) key_pool.push_back(rand64());
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 80) k = key_pool[$urandom_range(pool_size - 1)];
            else k = rand64();
            send_request(2'($urandom_range(3)), k, rand64());
        end
    endtask

    initial begin
        logic [8:0] phase_buckets [7];
        phase_buckets = '{9'd256, 9'd1, 9'd3, 9'd0, 9'd511, 9'd100, 9'd2};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: miss, insert, hit, update, create, delete at the field extremes
        send_request(KIND_GET,    64'd0, 64'd5);
        send_request(KIND_SET,    64'd0, '1);
        send_request(KIND_GET,    64'd0, 64'd0);
        send_request(KIND_SET,    64'd0, 64'h0123_4567_89ab_cdef);
        send_request(KIND_GETCRE, 64'd0, 64'd9);
        send_request(KIND_GETCRE, '1, 64'hfedc_ba98_7654_3210);
        send_request(KIND_GET,    '1, 64'd0);
        send_request(KIND_DEL,    '1, 64'd0);
        send_request(KIND_DEL,    '1, 64'd0);
        send_request(KIND_GET,    '1, 64'd0);
        send_request(KIND_DEL,    64'd0, '1);

        // Single bucket: fill all ways, then hit the full case with set and create
        write_buckets(9'd1);
        for (int i = 1; i <= 5; i++) send_request(KIND_SET, 64'(i), 64'(i * 3));
        send_request(KIND_GETCRE, 64'd77, 64'd1);
        send_request(KIND_SET,    64'd3, 64'd42);
        send_request(KIND_DEL,    64'd2, 64'd0);
        send_request(KIND_GETCRE, 64'd77, 64'd11);
        send_request(KIND_GET,    64'd77, 64'd0);

        for (int p = 0; p < 7; p++) begin
            write_buckets(phase_buckets[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            random_words(100, (phase_buckets[p] <= 3) ? 10 : 40);
        end
        req.valid <= 1'b0;
        recv_stall_pct = 0;

        while (board.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/hkvt_pkg.sv
rtl/core/hkvt_if.sv
rtl/core/hkvt_hash.sv
rtl/core/hashed_key_value_table_core.sv
verif/hashed_key_value_table_core_test.sv
